### src/ncc_pkg.sv
`timescale 1ns / 1ps

package ncc_pkg;

  // distance accumulator width and saturation value
  localparam int DIST_BITS = 36;
  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  // magnitudes at or above 2^SQ_IN_BITS saturate the square
  localparam int SQ_IN_BITS = 18;

  // fixed field widths
  localparam int OUT_W     = 5;
  localparam int CLUSTER_W = 4;
  localparam int DIM_W     = 3;
  localparam int NCLUS_W   = 5;
  localparam int NDIMS_W   = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 5;

  // result when no centroid coordinate has been loaded
  localparam logic [OUT_W-1:0] NO_CLUSTER = '1;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_POINT = 1'b1
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_CLUSTERS = 1'b0,
    CFG_NUM_DIMS     = 1'b1
  } cfg_reg_t;

endpackage

### src/nearest_centroid_classifier_core.sv
`timescale 1ns / 1ps

// Nearest-centroid classifier (k-means assignment step).
// Input channel (in_valid / in_stall): in_req_type = REQ_LOAD writes one centroid
// coordinate at (in_cluster_index, in_dim_index); REQ_POINT supplies the next
// coordinate of the point under test. Loads go back to back.
// Each point coordinate sweeps all MAX_CLUSTERS centroids through the centroid and
// distance memories, one cluster per cycle, over the single centroid read port;
// the input stalls until the sweep and the pipeline drain (S_SWEEP, S_DRAIN) end.
// After num_dims point coordinates one transfer on the output channel
// (out_valid / out_stall) carries the nearest centroid index, ties to the lowest
// index, or -1 if no centroid was ever loaded. out_valid rises from S_EMIT once the
// output register is free. The result is registered; while the receiver stalls it
// holds, and further non-final point coordinates and loads are still taken. A final
// coordinate waits for the output register to free up.
// Configuration (cfg_valid / cfg_ready, always ready): index CFG_NUM_CLUSTERS and
// CFG_NUM_DIMS, both 1 after reset. Write only while the block is idle.
// Reset (rst_n, synchronous) clears the coordinate count, the loaded flag and the
// valid flags, not the running distances; the centroid table is undefined until written.

module nearest_centroid_classifier_core
  import ncc_pkg::*;
#(
  parameter int MAX_CLUSTERS = 16,
  parameter int MAX_DIMS     = 8,
  parameter int VALUE_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [CLUSTER_W-1:0]          in_cluster_index,
  input  logic [DIM_W-1:0]              in_dim_index,
  input  logic signed [VALUE_BITS-1:0]  in_coord_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [OUT_W-1:0]       out_nearest_cluster,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DAT_W-1:0]          cfg_data
);

  localparam int CW     = $clog2(MAX_CLUSTERS);
  localparam int DW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DEPTH  = MAX_CLUSTERS * MAX_DIMS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int KN_W   = $clog2(MAX_CLUSTERS + 1);
  localparam int KC_W   = (KN_W > NCLUS_W) ? KN_W : NCLUS_W;
  localparam int DN_W   = $clog2(MAX_DIMS + 1);
  localparam int DC_W   = (DN_W > NDIMS_W) ? DN_W : NDIMS_W;
  localparam int EXT_W  = (VALUE_BITS + 1 > SQ_IN_BITS) ? VALUE_BITS + 1 : SQ_IN_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t state_r;

  logic [NCLUS_W-1:0]          num_clusters_r;
  logic [NDIMS_W-1:0]          num_dims_r;
  logic                        loaded_r;
  logic [DW-1:0]               cnt_r;

  // current point coordinate
  logic [VALUE_BITS-1:0]       val_r;
  logic [DW-1:0]               dim_r;
  logic                        first_r;
  logic                        last_r;
  logic [CW-1:0]               c_r;

  // pipeline
  logic                        p1_vld_r;
  logic [CW-1:0]               p1_c_r;
  logic                        p2_vld_r;
  logic [CW-1:0]               p2_c_r;
  logic [DIST_BITS-1:0]        sq_r;
  logic [DIST_BITS-1:0]        dist_hold_r;

  logic [CW-1:0]               best_r;
  logic [DIST_BITS-1:0]        best_d_r;

  logic                        out_valid_r;
  logic [OUT_W-1:0]            out_nc_r;

  // memories
  logic [VALUE_BITS-1:0]       tab_mem [DEPTH];
  logic [VALUE_BITS-1:0]       tab_q;
  logic [DIST_BITS-1:0]        dist_mem [MAX_CLUSTERS];
  logic [DIST_BITS-1:0]        dist_q;

  logic                        in_xfer;
  logic                        load_ok;
  logic                        tab_we;
  logic [ADDR_W-1:0]           tab_waddr;
  logic [ADDR_W-1:0]           tab_raddr;
  logic [KC_W-1:0]             nk_raw;
  logic [KC_W-1:0]             nk;
  logic [DC_W-1:0]             nd_raw;
  logic [DC_W-1:0]             nd;
  logic [DC_W-1:0]             cnt_inc;
  logic                        is_last;
  logic                        out_free;

  logic [VALUE_BITS:0]         diff;
  logic [VALUE_BITS:0]         mag;
  logic [EXT_W-1:0]            mag_ext;
  logic [SQ_IN_BITS-1:0]       mag_lo;
  logic [DIST_BITS-1:0]        sq_nxt;
  logic [DIST_BITS-1:0]        dist_base;
  logic [DIST_BITS:0]          sum_w;
  logic [DIST_BITS-1:0]        dist_sum;

  assign in_stall            = (state_r != S_IDLE);
  assign in_xfer             = in_valid && !in_stall;
  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_nearest_cluster = out_nc_r;
  assign out_free            = !out_valid_r || !out_stall;

  // clamp registers into their legal ranges
  always_comb begin
    nk_raw = KC_W'(num_clusters_r);
    if (nk_raw == '0) begin
      nk = KC_W'(1);
    end else if (nk_raw > KC_W'(MAX_CLUSTERS)) begin
      nk = KC_W'(MAX_CLUSTERS);
    end else begin
      nk = nk_raw;
    end
    nd_raw = DC_W'(num_dims_r);
    if (nd_raw == '0) begin
      nd = DC_W'(1);
    end else if (nd_raw > DC_W'(MAX_DIMS)) begin
      nd = DC_W'(MAX_DIMS);
    end else begin
      nd = nd_raw;
    end
    cnt_inc = DC_W'(cnt_r) + DC_W'(1);
    is_last = (cnt_inc >= nd);
  end

  assign load_ok   = (32'(in_cluster_index) < MAX_CLUSTERS) && (32'(in_dim_index) < MAX_DIMS);
  assign tab_we    = in_xfer && (in_req_type == REQ_LOAD) && load_ok;
  assign tab_waddr = ADDR_W'(32'(in_cluster_index) * MAX_DIMS + 32'(in_dim_index));
  assign tab_raddr = ADDR_W'(32'(c_r) * MAX_DIMS + 32'(dim_r));

  // stage 1: squared difference
  always_comb begin
    diff    = {val_r[VALUE_BITS-1], val_r} - {tab_q[VALUE_BITS-1], tab_q};
    mag     = diff[VALUE_BITS] ? (~diff + 1'b1) : diff;
    mag_ext = EXT_W'(mag);
    mag_lo  = mag_ext[SQ_IN_BITS-1:0];
    if ((mag_ext >> SQ_IN_BITS) != '0) begin
      sq_nxt = DIST_MAX;
    end else begin
      sq_nxt = DIST_BITS'(mag_lo) * DIST_BITS'(mag_lo);
    end
  end

  // stage 2: saturating accumulate; distances count as zero on a point's first coordinate
  always_comb begin
    dist_base = first_r ? '0 : dist_hold_r;
    sum_w     = {1'b0, dist_base} + {1'b0, sq_r};
    dist_sum  = sum_w[DIST_BITS] ? DIST_MAX : sum_w[DIST_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= in_coord_value;
    end
    tab_q <= tab_mem[tab_raddr];
  end

  always_ff @(posedge clk) begin
    if (p2_vld_r) begin
      dist_mem[p2_c_r] <= dist_sum;
    end
    dist_q <= dist_mem[c_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      num_clusters_r <= NCLUS_W'(1);
      num_dims_r     <= NDIMS_W'(1);
      loaded_r       <= 1'b0;
      cnt_r          <= '0;
      c_r            <= '0;
      p1_vld_r       <= 1'b0;
      p2_vld_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_NUM_CLUSTERS: num_clusters_r <= cfg_data[NCLUS_W-1:0];
          CFG_NUM_DIMS:     num_dims_r     <= cfg_data[NDIMS_W-1:0];
          default:          ;
        endcase
      end

      // S_EMIT owns out_valid_r while it is active
      if (out_valid_r && !out_stall && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      p1_vld_r    <= (state_r == S_SWEEP);
      p1_c_r      <= c_r;
      sq_r        <= sq_nxt;
      dist_hold_r <= dist_q;
      p2_vld_r    <= p1_vld_r;
      p2_c_r      <= p1_c_r;

      // running minimum over the first nk clusters, only needed on the final coordinate
      if (p2_vld_r) begin
        if (p2_c_r == '0) begin
          best_r   <= '0;
          best_d_r <= dist_sum;
        end else if ((KC_W'(p2_c_r) < nk) && (dist_sum < best_d_r)) begin
          best_r   <= p2_c_r;
          best_d_r <= dist_sum;
        end
      end

      unique case (state_r)
        S_IDLE: begin
          c_r <= '0;
          if (in_xfer) begin
            if (in_req_type == REQ_LOAD) begin
              if (load_ok) begin
                loaded_r <= 1'b1;
              end
            end else begin
              val_r   <= in_coord_value;
              dim_r   <= cnt_r;
              first_r <= (cnt_r == '0);
              last_r  <= is_last;
              cnt_r   <= is_last ? '0 : DW'(cnt_inc);
              state_r <= S_SWEEP;
            end
          end
        end
        S_SWEEP: begin
          c_r <= c_r + 1'b1;
          if (c_r == CW'(MAX_CLUSTERS - 1)) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          c_r <= '0;
          if (!p1_vld_r && !p2_vld_r) begin
            state_r <= last_r ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_nc_r    <= loaded_r ? OUT_W'(best_r) : NO_CLUSTER;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### dv/tb_nearest_centroid_classifier_core.sv
`timescale 1ns / 1ps

module tb_nearest_centroid_classifier_core;
  import ncc_pkg::*;

  localparam int MAX_CLUSTERS     = 16;
  localparam int MAX_DIMS         = 8;
  localparam int VALUE_BITS       = 16;
  // one point coordinate sweeps every cluster before the input frees up
  localparam int SETTLE_CYCLES    = 48;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS     = 1100;
  localparam int CALM_ITEMS       = 150;
  localparam int MAX_REPORTS      = 10;
  localparam int NUM_ROWS         = 32;
  localparam longint TIMEOUT_NS   = 5_000_000;

  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_POINT,
    ROW_CFG,
    ROW_FILL
  } row_kind_t;

  typedef struct packed {
    row_kind_t                    kind;
    logic [CLUSTER_W-1:0]         cluster;
    logic [DIM_W-1:0]             dim;
    logic signed [VALUE_BITS-1:0] value;
    cfg_reg_t                     creg;
    logic [CFG_DAT_W-1:0]         cdata;
    logic                         typed;
    logic [OUT_W-1:0]             want;
  } row_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic                         in_req_type;
  logic [CLUSTER_W-1:0]         in_cluster_index;
  logic [DIM_W-1:0]             in_dim_index;
  logic signed [VALUE_BITS-1:0] in_coord_value;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [OUT_W-1:0]      out_nearest_cluster;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DAT_W-1:0]         cfg_data;

  nearest_centroid_classifier_core #(
    .MAX_CLUSTERS(MAX_CLUSTERS),
    .MAX_DIMS    (MAX_DIMS),
    .VALUE_BITS  (VALUE_BITS)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_cluster_index   (in_cluster_index),
    .in_dim_index       (in_dim_index),
    .in_coord_value     (in_coord_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_nearest_cluster(out_nearest_cluster),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // classifier state as the testbench sees it
  logic signed [VALUE_BITS-1:0] cent_mem [MAX_CLUSTERS][MAX_DIMS];
  logic [DIST_BITS-1:0]         dist_acc [MAX_CLUSTERS];
  int unsigned                  coord_cnt = 0;
  bit                           any_loaded = 1'b0;
  logic [NCLUS_W-1:0]           nclus_q = 1;
  logic [NDIMS_W-1:0]           ndims_q = 1;

  logic [OUT_W-1:0] pending_nearest [$];
  int               fail_cnt = 0;
  int               idle_pct = 0;
  bit               hold_request = 1'b0;

  // after the fill row, centroid k holds k.0 in every coordinate
  row_t plan [NUM_ROWS] = '{
    '{ROW_POINT, 4'd0, 3'd0, 16'sh0000, CFG_NUM_CLUSTERS, 5'd0, 1'b1, NO_CLUSTER},
    '{ROW_POINT, 4'd0, 3'd0, 16'sh8000, CFG_NUM_CLUSTERS, 5'd0, 1'b1, NO_CLUSTER},
    '{ROW_FILL, 4'd0, 3'd0, 16'sh0000, CFG_NUM_CLUSTERS, 5'd0, 1'b0, 5'd0},
    '{ROW_CFG, 4'd0, 3'd0, 16'sh0000, CFG_NUM_CLUSTERS, 5'd16, 1'b0, 5'd0},
    '{ROW_POINT, 4'd0, 3'd0, 16'sh0500, CFG_NUM_CLUSTERS, 5'd0, 1'b1, 5'd5},
    '{ROW_POINT, 4'd0, 3'd0, 16'sh7fff, CFG_NUM_CLUSTERS, 5'd0, 1'b1, 5'd15},
    '{ROW_POINT, 4'd0, 3'd0, 16'sh8000, CFG_NUM_CLUSTERS, 5'd0, 1'b1, 5'd0},
    // 2.5 sits halfway between 2 and 3: lower index wins
    '{ROW_POINT, 4'd0, 3'd0, 16'sh0280, CFG_NUM_CLUSTERS, 5'd0, 1'b1, 5'd2},
    // zero clamps to one cluster
    '{ROW_CFG, 4'd0, 3'd0, 16'sh0000, CFG_NUM_CLUSTERS, 5'd0, 1'b0, 5'd0},
    '{ROW_POINT, 4'd0, 3'd0, 16'sh0f00, CFG_NUM_CLUSTERS, 5'd0, 1'b1, 5'd0},
    '{ROW_CFG, 4'd0, 3'd0, 16'sh0000, CFG_NUM_CLUSTERS, 5'd31, 1'b0, 5'd0},
    '{ROW_POINT, 4'd0, 3'd0, 16'sh0d80, CFG_NUM_CLUSTERS, 5'd0, 1'b1, 5'd13},
    '{ROW_CFG, 4'd0, 3'd0, 16'sh0000, CFG_NUM_DIMS, 5'd0, 1'b0, 5'd0},
    '{ROW_POINT, 4'd0, 3'd0, 16'sh0400, CFG_NUM_CLUSTERS, 5'd0, 1'b1, 5'd4},
    '{ROW_LOAD, 4'd15, 3'd0, 16'sh8000, CFG_NUM_CLUSTERS, 5'd0, 1'b0, 5'd0},
    '{ROW_POINT, 4'd0, 3'd0, 16'sh8000, CFG_NUM_CLUSTERS, 5'd0, 1'b1, 5'd15},
    '{ROW_LOAD, 4'd15, 3'd0, 16'sh0f00, CFG_NUM_CLUSTERS, 5'd0, 1'b0, 5'd0},
    // 31 keeps the low four bits, 15 clamps to eight dims
    '{ROW_CFG, 4'd0, 3'd0, 16'sh0000, CFG_NUM_DIMS, 5'd31, 1'b0, 5'd0},
    '{ROW_POINT, 4'd9, 3'd5, 16'sh0300, CFG_NUM_CLUSTERS, 5'd0, 1'b0, 5'd0},
    '{ROW_POINT, 4'd0, 3'd0, 16'sh0300, CFG_NUM_CLUSTERS, 5'd0, 1'b0, 5'd0},
    '{ROW_POINT, 4'd0, 3'd0, 16'sh0300, CFG_NUM_CLUSTERS, 5'd0, 1'b0, 5'd0},
    // load lands in the middle of a point
    '{ROW_LOAD, 4'd0, 3'd7, 16'sh7fff, CFG_NUM_CLUSTERS, 5'd0, 1'b0, 5'd0},
    '{ROW_POINT, 4'd0, 3'd0, 16'sh0300, CFG_NUM_CLUSTERS, 5'd0, 1'b0, 5'd0},
    '{ROW_POINT, 4'd0, 3'd0, 16'sh0300, CFG_NUM_CLUSTERS, 5'd0, 1'b0, 5'd0},
    '{ROW_POINT, 4'd0, 3'd0, 16'sh0300, CFG_NUM_CLUSTERS, 5'd0, 1'b0, 5'd0},
    '{ROW_POINT, 4'd0, 3'd0, 16'sh0300, CFG_NUM_CLUSTERS, 5'd0, 1'b0, 5'd0},
    '{ROW_POINT, 4'd0, 3'd0, 16'sh0300, CFG_NUM_CLUSTERS, 5'd0, 1'b1, 5'd3},
    // dims shrink while a point is half done
    '{ROW_CFG, 4'd0, 3'd0, 16'sh0000, CFG_NUM_DIMS, 5'd3, 1'b0, 5'd0},
    '{ROW_POINT, 4'd0, 3'd0, 16'sh1234, CFG_NUM_CLUSTERS, 5'd0, 1'b0, 5'd0},
    '{ROW_POINT, 4'd0, 3'd0, 16'shedcb, CFG_NUM_CLUSTERS, 5'd0, 1'b0, 5'd0},
    '{ROW_CFG, 4'd0, 3'd0, 16'sh0000, CFG_NUM_DIMS, 5'd2, 1'b0, 5'd0},
    '{ROW_POINT, 4'd0, 3'd0, 16'sh7f00, CFG_NUM_CLUSTERS, 5'd0, 1'b0, 5'd0}
  };

  function automatic void flag_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic void classify_step(input req_type_t rq,
      input logic [CLUSTER_W-1:0] ci, input logic [DIM_W-1:0] di,
      input logic signed [VALUE_BITS-1:0] v,
      output bit emits, output logic [OUT_W-1:0] idx);
    int     nk, nd, best;
    longint diff, sum;
    emits = 1'b0;
    idx = '0;
    if (rq == REQ_LOAD) begin
      // every 4-bit cluster and 3-bit dim index fits the table
      cent_mem[ci][di] = v;
      any_loaded = 1'b1;
      return;
    end
    nk = int'(nclus_q);
    if (nk < 1) nk = 1;
    if (nk > MAX_CLUSTERS) nk = MAX_CLUSTERS;
    nd = int'(ndims_q);
    if (nd < 1) nd = 1;
    if (nd > MAX_DIMS) nd = MAX_DIMS;
    if (coord_cnt < MAX_DIMS) begin
      for (int c = 0; c < MAX_CLUSTERS; c++) begin
        diff = longint'(v) - longint'(cent_mem[c][coord_cnt]);
        sum = longint'(dist_acc[c]) + diff * diff;
        dist_acc[c] = (sum > longint'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];
      end
    end
    coord_cnt++;
    if (coord_cnt < nd) return;
    emits = 1'b1;
    if (!any_loaded) begin
      idx = NO_CLUSTER;
    end else begin
      best = 0;
      for (int c = 1; c < nk; c++)
        if (dist_acc[c] < dist_acc[best]) best = c;
      idx = best[OUT_W-1:0];
    end
    foreach (dist_acc[c]) dist_acc[c] = '0;
    coord_cnt = 0;
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] point_value();
    int k, t;
    k = $urandom_range(0, MAX_CLUSTERS - 1);
    case ($urandom_range(0, 7))
      0, 1: return VALUE_BITS'($urandom);
      // lands exactly on a centroid coordinate
      2: return cent_mem[k][coord_cnt];
      3: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: begin
        t = int'(cent_mem[k][coord_cnt]) + int'($urandom_range(0, 600)) - 300;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        return VALUE_BITS'(t);
      end
    endcase
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] load_value(
      input logic [DIM_W-1:0] di);
    case ($urandom_range(0, 5))
      // duplicate another centroid's coordinate so that ties show up
      0, 1: return cent_mem[$urandom_range(0, MAX_CLUSTERS - 1)][di];
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  task automatic send_item(input req_type_t rq, input logic [CLUSTER_W-1:0] ci,
      input logic [DIM_W-1:0] di, input logic signed [VALUE_BITS-1:0] v,
      input bit typed = 1'b0, input logic [OUT_W-1:0] want = '0);
    bit               emits;
    logic [OUT_W-1:0] idx;
    if ($urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= rq;
    in_cluster_index <= ci;
    in_dim_index     <= di;
    in_coord_value   <= v;
    do @(posedge clk); while (in_stall !== 1'b0);
    classify_step(rq, ci, di, v, emits, idx);
    if (emits) pending_nearest = {pending_nearest, typed ? want : idx};
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_nearest.size() != 0) @(posedge clk);
    // a trailing partial point may still be sweeping
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    if (idx == CFG_NUM_CLUSTERS) nclus_q = val;
    else ndims_q = val[NDIMS_W-1:0];
  endtask

  // result side stall pattern, plus one long hold to back the block up
  initial begin
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(1, 100) <= idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    logic [OUT_W-1:0] wanted;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_nearest.size() == 0) begin
        flag_fail($sformatf("unexpected transfer: nearest_cluster %0d",
                            $signed(out_nearest_cluster)));
      end else begin
        wanted = pending_nearest.pop_front();
        if (out_nearest_cluster !== wanted)
          flag_fail($sformatf("nearest_cluster mismatch: expected %0d, got %0d",
                              $signed(wanted), $signed(out_nearest_cluster)));
      end
    end
  end

  initial begin
    row_t r;
    int   sent, nk, nd, span;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_req_type      <= REQ_LOAD;
    in_cluster_index <= '0;
    in_dim_index     <= '0;
    in_coord_value   <= '0;
    cfg_valid        <= 1'b0;
    cfg_index        <= CFG_NUM_CLUSTERS;
    cfg_data         <= '0;
    foreach (cent_mem[c, d]) cent_mem[c][d] = '0;
    foreach (dist_acc[c]) dist_acc[c] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct = 10;
    for (int i = 0; i < NUM_ROWS; i++) begin
      r = plan[i];
      case (r.kind)
        ROW_LOAD:  send_item(REQ_LOAD, r.cluster, r.dim, r.value);
        ROW_POINT: send_item(REQ_POINT, r.cluster, r.dim, r.value, r.typed, r.want);
        ROW_CFG:   write_reg(r.creg, r.cdata);
        ROW_FILL: begin
          for (int c = 0; c < MAX_CLUSTERS; c++)
            for (int d = 0; d < MAX_DIMS; d++)
              send_item(REQ_LOAD, c[CLUSTER_W-1:0], d[DIM_W-1:0], VALUE_BITS'(c * 256));
        end
        default: ;
      endcase
    end

    sent = 0;
    for (int ph = 0; sent < RANDOM_ITEMS; ph++) begin
      case (ph)
        0: begin nk = MAX_CLUSTERS; nd = MAX_DIMS; end
        1: begin nk = 1; nd = 1; end
        2: begin nk = MAX_CLUSTERS; nd = 1; end
        3: begin nk = 1; nd = MAX_DIMS; end
        default: begin
          nk = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                           : $urandom_range(1, MAX_CLUSTERS);
          nd = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                           : $urandom_range(1, MAX_DIMS);
        end
      endcase
      if (sent >= RANDOM_ITEMS - CALM_ITEMS) idle_pct = 0;
      write_reg(CFG_NUM_CLUSTERS, CFG_DAT_W'(nk));
      write_reg(CFG_NUM_DIMS, CFG_DAT_W'(nd));
      case ($urandom_range(0, 3))
        0: idle_pct = 0;
        1: idle_pct = 25;
        default: idle_pct = 8;
      endcase
      if (ph == 0) begin
        // fresh random table before the random points
        for (int c = 0; c < MAX_CLUSTERS; c++)
          for (int d = 0; d < MAX_DIMS; d++)
            send_item(REQ_LOAD, c[CLUSTER_W-1:0], d[DIM_W-1:0], VALUE_BITS'($urandom));
        sent += MAX_CLUSTERS * MAX_DIMS;
      end
      if (ph == 5) hold_request = 1'b1;
      span = $urandom_range(60, 140);
      for (int n = 0; n < span && sent < RANDOM_ITEMS; n++) begin
        if (sent >= RANDOM_ITEMS - CALM_ITEMS) idle_pct = 0;
        if ($urandom_range(0, 5) == 0) begin
          nd = $urandom_range(0, MAX_DIMS - 1);
          send_item(REQ_LOAD, CLUSTER_W'($urandom), DIM_W'(nd), load_value(DIM_W'(nd)));
        end else begin
          send_item(REQ_POINT, CLUSTER_W'($urandom), DIM_W'($urandom), point_value());
        end
        sent++;
      end
    end

    idle_pct = 0;
    in_valid <= 1'b0;
    while (pending_nearest.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("nearest_centroid_classifier_core verification clean");
    end else begin
      $display("nearest_centroid_classifier_core verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("nearest_centroid_classifier_core verification failed");
    $finish;
  end

endmodule
